>>> sv/v3a_pkg.sv
`timescale 1ns / 1ps

package v3a_pkg;

  // Width of every vector and scalar field on the ports.
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned FUNC_W  = 4;
  localparam int unsigned MAG_W   = 16;

  // Reset value of the minimum magnitude register.
  localparam logic [MAG_W-1:0] MIN_MAG_RST = 16'd7;

  // Operation codes. Codes above FN_INV give an all-zero result.
  typedef enum logic [FUNC_W-1:0] {
    FN_COPY  = 4'd0,
    FN_ADD   = 4'd1,
    FN_SUB   = 4'd2,
    FN_SCALE = 4'd3,
    FN_DOT   = 4'd4,
    FN_CROSS = 4'd5,
    FN_MAG   = 4'd6,
    FN_NORM  = 4'd7,
    FN_DIST  = 4'd8,
    FN_LERP  = 4'd9,
    FN_INV   = 4'd10
  } func_e;

  // One input transaction.
  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [FIELD_W-1:0] a_x;
    logic signed [FIELD_W-1:0] a_y;
    logic signed [FIELD_W-1:0] a_z;
    logic signed [FIELD_W-1:0] b_x;
    logic signed [FIELD_W-1:0] b_y;
    logic signed [FIELD_W-1:0] b_z;
    logic signed [FIELD_W-1:0] scalar_in;
  } v3a_in_t;

  // One result transaction.
  typedef struct packed {
    logic signed [FIELD_W-1:0] res_x;
    logic signed [FIELD_W-1:0] res_y;
    logic signed [FIELD_W-1:0] res_z;
    logic signed [FIELD_W-1:0] res_scalar;
    logic                      saturated;
  } v3a_out_t;

  // Side data that follows a transaction down the pipeline.
  typedef struct packed {
    logic [FUNC_W-1:0]            func;
    logic [2:0][FIELD_W-1:0]      a;
    v3a_out_t                     res;
  } v3a_carry_t;

endpackage

>>> sv/vector3_alu.sv
`timescale 1ns / 1ps

// Three-component vector ALU on signed fixed point (FRAC_BITS fraction bits,
// DATA_WIDTH significant bits per field). A transaction is taken on any
// cycle with start high; busy is always low, so one transaction may enter
// every clock. Each result appears on res_o for exactly one cycle with done_o
// high, in order and whatever the operation. A transaction passes through the
// multiplier front end, the square-root pipeline, which resolves one root bit
// per stage, the threshold stage, the normalising divider, which resolves one
// quotient bit per stage, and the output register. The result cannot be held
// off, so it must be captured in the cycle that done_o is high. The minimum
// magnitude register should be written only while no transaction is in flight.
module vector3_alu #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  v3a_pkg::v3a_in_t         in_i,
  input  logic                     cfg_we_i,
  input  logic [v3a_pkg::MAG_W-1:0] cfg_data_i,
  output logic                     done_o,
  output v3a_pkg::v3a_out_t        res_o
);
  import v3a_pkg::*;

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned RW  = W + 2;
  localparam int unsigned SW  = 2 * RW;
  localparam int unsigned QW  = FRAC_BITS + 1;
  localparam int unsigned NEW = ((QW > W) ? QW : W) + 2;
  localparam int unsigned LAT = 3 + RW + 1 + QW + 1;
  localparam logic [RW-1:0] HI_M = RW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic signed [NEW-1:0] HI_Q = NEW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [NEW-1:0] LO_Q = -HI_Q - NEW'(1);

  function automatic logic [FIELD_W-1:0] ext32(input logic signed [W-1:0] v);
    return FIELD_W'(v);
  endfunction

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Minimum magnitude register.
  logic [MAG_W-1:0] min_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_mag_q <= MIN_MAG_RST;
    end else if (cfg_we_i) begin
      min_mag_q <= cfg_data_i;
    end
  end

  // Multiplier front end.
  logic          f_valid;
  v3a_carry_t    f_carry;
  logic [SW-1:0] f_sum;

  v3a_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .in_i    (in_i),
    .valid_o (f_valid),
    .carry_o (f_carry),
    .sum_o   (f_sum)
  );

  // Square root of the sum of squares.
  logic [RW-1:0] root;

  v3a_sqrt #(
    .RW (RW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .val_i  (f_sum),
    .root_o (root)
  );

  // Side data waits alongside the square root.
  v3a_carry_t ca_q [RW];
  logic       va_q [RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RW; k++) va_q[k] <= 1'b0;
    end else begin
      va_q[0] <= f_valid;
      for (int k = 1; k < RW; k++) va_q[k] <= va_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ca_q[0] <= f_carry;
    for (int k = 1; k < RW; k++) ca_q[k] <= ca_q[k-1];
  end

  // Threshold stage: apply the minimum magnitude and prepare the divide.
  v3a_carry_t          ct_d, ct_q;
  logic [RW-1:0]       m_d, mt_q;
  logic [W-1:0]        abs_d [3];
  logic [W-1:0]        abst_q [3];
  logic [2:0]          neg_d, negt_q;
  logic                vt_q;
  logic signed [W-1:0] sa [3];

  always_comb begin
    m_d  = (root < RW'(min_mag_q)) ? '0 : root;
    ct_d = ca_q[RW-1];
    if (ct_d.func == FN_MAG || ct_d.func == FN_DIST) begin
      ct_d.res.res_scalar = (m_d > HI_M) ? ext32(HI_M[W-1:0]) : ext32(m_d[W-1:0]);
      ct_d.res.saturated  = m_d > HI_M;
    end
    for (int i = 0; i < 3; i++) begin
      sa[i]    = ca_q[RW-1].a[i][W-1:0];
      neg_d[i] = sa[i][W-1];
      abs_d[i] = neg_d[i] ? (~sa[i] + W'(1)) : sa[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q <= 1'b0;
    end else begin
      vt_q <= va_q[RW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ct_q   <= ct_d;
    mt_q   <= m_d;
    negt_q <= neg_d;
    for (int i = 0; i < 3; i++) abst_q[i] <= abs_d[i];
  end

  // One divider for each component of a normalised vector.
  logic [QW-1:0] quo [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3a_div #(
      .NW (W),
      .DW (RW),
      .QW (QW)
    ) u_div (
      .clk_i (clk_i),
      .num_i (abst_q[i]),
      .den_i (mt_q),
      .quo_o (quo[i])
    );
  end

  // Side data waits alongside the dividers.
  v3a_carry_t cb_q   [QW];
  logic       vb_q   [QW];
  logic [2:0] negb_q [QW];
  logic       mzb_q  [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QW; k++) vb_q[k] <= 1'b0;
    end else begin
      vb_q[0] <= vt_q;
      for (int k = 1; k < QW; k++) vb_q[k] <= vb_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    cb_q[0]   <= ct_q;
    negb_q[0] <= negt_q;
    mzb_q[0]  <= (mt_q == '0);
    for (int k = 1; k < QW; k++) begin
      cb_q[k]   <= cb_q[k-1];
      negb_q[k] <= negb_q[k-1];
      mzb_q[k]  <= mzb_q[k-1];
    end
  end

  // Output stage: finish normalise and register the transaction.
  v3a_out_t              out_d, out_q;
  logic                  done_q;
  logic signed [NEW-1:0] qs [3];
  logic signed [W-1:0]   rq [3];
  logic                  fq;

  always_comb begin
    out_d = cb_q[QW-1].res;
    fq    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      qs[i] = negb_q[QW-1][i] ? -NEW'(quo[i]) : NEW'(quo[i]);
      if (qs[i] > HI_Q) begin
        rq[i] = HI_Q[W-1:0];
      end else if (qs[i] < LO_Q) begin
        rq[i] = LO_Q[W-1:0];
      end else begin
        rq[i] = qs[i][W-1:0];
      end
      fq = fq | (qs[i] > HI_Q) | (qs[i] < LO_Q);
    end
    if (cb_q[QW-1].func == FN_NORM) begin
      if (mzb_q[QW-1]) begin
        // A vector too short to normalise passes through unchanged.
        out_d.res_x     = cb_q[QW-1].a[0];
        out_d.res_y     = cb_q[QW-1].a[1];
        out_d.res_z     = cb_q[QW-1].a[2];
        out_d.saturated = 1'b0;
      end else begin
        out_d.res_x     = ext32(rq[0]);
        out_d.res_y     = ext32(rq[1]);
        out_d.res_z     = ext32(rq[2]);
        out_d.saturated = fq;
      end
      out_d.res_scalar = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vb_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o = done_q;
  assign res_o  = out_q;

  // Every accepted transaction comes out after the fixed latency.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o)
    else $error("transaction did not complete after the pipeline latency");

  // Normalise never reports a scalar.
  a_norm_scalar : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q[QW-1] && (cb_q[QW-1].func == FN_NORM) |=> done_o && (res_o.res_scalar == '0))
    else $error("normalise produced a nonzero scalar");

  // A copy is never flagged as clamped.
  a_copy_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q[QW-1] && (cb_q[QW-1].func == FN_COPY) |=> !res_o.saturated)
    else $error("copy raised the saturated flag");

endmodule

>>> sv/v3a_front.sv
`timescale 1ns / 1ps

module v3a_front #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  v3a_pkg::v3a_in_t          in_i,
  output logic                      valid_o,
  output v3a_pkg::v3a_carry_t       carry_o,
  output logic [2*DATA_WIDTH+3:0]   sum_o
);
  import v3a_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned OW = W + 1;
  localparam int unsigned PW = 2 * OW;
  localparam int unsigned EW = 2 * W + 4;
  localparam logic signed [EW-1:0] HI = EW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] LO = -HI - EW'(1);

  function automatic logic signed [W-1:0] clip(input logic signed [EW-1:0] v);
    if (v > HI) begin
      return HI[W-1:0];
    end else if (v < LO) begin
      return LO[W-1:0];
    end
    return v[W-1:0];
  endfunction

  function automatic logic hit(input logic signed [EW-1:0] v);
    return (v > HI) || (v < LO);
  endfunction

  function automatic logic [FIELD_W-1:0] ext32(input logic signed [W-1:0] v);
    return FIELD_W'(v);
  endfunction

  // Operands taken from the low bits of each field.
  logic signed [W-1:0]  av [3];
  logic signed [W-1:0]  bv [3];
  logic signed [OW-1:0] ae [3];
  logic signed [OW-1:0] be [3];
  logic signed [OW-1:0] de [3];
  logic signed [OW-1:0] se;

  assign av[0] = in_i.a_x[W-1:0];
  assign av[1] = in_i.a_y[W-1:0];
  assign av[2] = in_i.a_z[W-1:0];
  assign bv[0] = in_i.b_x[W-1:0];
  assign bv[1] = in_i.b_y[W-1:0];
  assign bv[2] = in_i.b_z[W-1:0];
  assign se    = OW'($signed(in_i.scalar_in[W-1:0]));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ae[i] = OW'(av[i]);
      be[i] = OW'(bv[i]);
      de[i] = be[i] - ae[i];
    end
  end

  // Stage one: simple results and multiplier operand selection.
  v3a_carry_t           c1_d, c1_q;
  logic signed [OW-1:0] opx_d [6];
  logic signed [OW-1:0] opy_d [6];
  logic signed [OW-1:0] opx_q [6];
  logic signed [OW-1:0] opy_q [6];
  logic                 v1_q;
  logic signed [W-1:0]  r1 [3];
  logic                 f1;

  always_comb begin
    c1_d      = '0;
    c1_d.func = in_i.func;
    f1        = 1'b0;
    for (int i = 0; i < 3; i++) begin
      c1_d.a[i] = ext32(av[i]);
      r1[i]     = '0;
    end
    for (int k = 0; k < 6; k++) begin
      opx_d[k] = '0;
      opy_d[k] = '0;
    end
    unique case (in_i.func) inside
      FN_COPY: begin
        for (int i = 0; i < 3; i++) r1[i] = av[i];
      end
      FN_ADD: begin
        for (int i = 0; i < 3; i++) begin
          r1[i] = clip(EW'(ae[i]) + EW'(be[i]));
          f1    = f1 | hit(EW'(ae[i]) + EW'(be[i]));
        end
      end
      FN_SUB: begin
        for (int i = 0; i < 3; i++) begin
          r1[i] = clip(EW'(ae[i]) - EW'(be[i]));
          f1    = f1 | hit(EW'(ae[i]) - EW'(be[i]));
        end
      end
      FN_INV: begin
        for (int i = 0; i < 3; i++) begin
          r1[i] = clip(-EW'(ae[i]));
          f1    = f1 | hit(-EW'(ae[i]));
        end
      end
      FN_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          opx_d[i] = ae[i];
          opy_d[i] = se;
        end
      end
      FN_LERP: begin
        for (int i = 0; i < 3; i++) begin
          opx_d[i] = de[i];
          opy_d[i] = se;
        end
      end
      FN_DOT: begin
        for (int i = 0; i < 3; i++) begin
          opx_d[i] = ae[i];
          opy_d[i] = be[i];
        end
      end
      FN_CROSS: begin
        opx_d[0] = ae[1]; opy_d[0] = be[2];
        opx_d[3] = ae[2]; opy_d[3] = be[1];
        opx_d[1] = ae[2]; opy_d[1] = be[0];
        opx_d[4] = ae[0]; opy_d[4] = be[2];
        opx_d[2] = ae[0]; opy_d[2] = be[1];
        opx_d[5] = ae[1]; opy_d[5] = be[0];
      end
      FN_MAG, FN_NORM: begin
        for (int i = 0; i < 3; i++) begin
          opx_d[i] = ae[i];
          opy_d[i] = ae[i];
        end
      end
      FN_DIST: begin
        for (int i = 0; i < 3; i++) begin
          opx_d[i] = de[i];
          opy_d[i] = de[i];
        end
      end
      default: begin
      end
    endcase
    c1_d.res.res_x     = ext32(r1[0]);
    c1_d.res.res_y     = ext32(r1[1]);
    c1_d.res.res_z     = ext32(r1[2]);
    c1_d.res.saturated = f1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q <= c1_d;
    for (int k = 0; k < 6; k++) begin
      opx_q[k] <= opx_d[k];
      opy_q[k] <= opy_d[k];
    end
  end

  // Stage two: the six multipliers.
  v3a_carry_t           c2_q;
  logic signed [PW-1:0] p_q [6];
  logic                 v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c2_q <= c1_q;
    for (int k = 0; k < 6; k++) begin
      p_q[k] <= opx_q[k] * opy_q[k];
    end
  end

  // Stage three: truncate products and combine them.
  logic signed [PW-1:0] sh [6];
  logic signed [W-1:0]  a2 [3];
  logic signed [W-1:0]  r3 [3];
  logic signed [EW-1:0] t3 [3];
  logic signed [EW-1:0] dsum;
  logic signed [EW-1:0] sq;
  logic                 f3;
  v3a_carry_t           c3_d, c3_q;
  logic [EW-1:0]        sum_d, sum_q;
  logic                 v3_q;

  always_comb begin
    for (int k = 0; k < 6; k++) sh[k] = p_q[k] >>> FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      a2[i] = c2_q.a[i][W-1:0];
      r3[i] = '0;
      t3[i] = '0;
    end
    c3_d = c2_q;
    f3   = 1'b0;
    dsum = EW'(sh[0]) + EW'(sh[1]) + EW'(sh[2]);
    sq   = EW'(p_q[0]) + EW'(p_q[1]) + EW'(p_q[2]);
    sum_d = sq;
    unique case (c2_q.func) inside
      FN_SCALE, FN_LERP, FN_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          if (c2_q.func == FN_SCALE) begin
            t3[i] = EW'(sh[i]);
          end else if (c2_q.func == FN_LERP) begin
            t3[i] = EW'(a2[i]) + EW'(sh[i]);
          end else begin
            t3[i] = EW'(sh[i]) - EW'(sh[i+3]);
          end
          r3[i] = clip(t3[i]);
          f3    = f3 | hit(t3[i]);
        end
        c3_d.res.res_x     = ext32(r3[0]);
        c3_d.res.res_y     = ext32(r3[1]);
        c3_d.res.res_z     = ext32(r3[2]);
        c3_d.res.saturated = f3;
      end
      FN_DOT: begin
        c3_d.res.res_scalar = ext32(clip(dsum));
        c3_d.res.saturated  = hit(dsum);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c3_q  <= c3_d;
    sum_q <= sum_d;
  end

  assign valid_o = v3_q;
  assign carry_o = c3_q;
  assign sum_o   = sum_q;

endmodule

>>> sv/v3a_sqrt.sv
`timescale 1ns / 1ps

// Floor square root, one root bit per pipeline stage.
module v3a_sqrt #(
  parameter int unsigned RW = 34
) (
  input  logic            clk_i,
  input  logic [2*RW-1:0] val_i,
  output logic [RW-1:0]   root_o
);

  logic [RW+1:0]   rem_q  [RW-1];
  logic [2*RW-1:0] val_q  [RW-1];
  logic [RW-1:0]   root_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] val_in;
    logic [RW+3:0]   cur;
    logic [RW+3:0]   trial;
    logic            take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = val_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign val_in  = val_q[k-1];
    end

    // Bring down the next bit pair and try the next root bit.
    assign cur   = {rem_in, val_in[2*RW-1 -: 2]};
    assign trial = (RW + 4)'({root_in, 2'b01});
    assign take  = cur >= trial;

    always_ff @(posedge clk_i) begin
      root_q[k] <= {root_in[RW-2:0], take};
    end

    if (k < RW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k] <= take ? (RW + 2)'(cur - trial) : cur[RW+1:0];
        val_q[k] <= {val_in[2*RW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

>>> sv/v3a_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per pipeline stage. The caller must
// guarantee that the quotient fits QW bits and the divisor is nonzero (unchecked).
module v3a_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 34,
  parameter int unsigned QW = 17
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [QW-1];
  logic [DW-1:0] den_q [QW-1];
  logic [QW-1:0] q_q   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic          bit_in;
    logic [DW:0]   cur;
    logic          take;

    // The numerator is the magnitude shifted up, so only its lowest bit
    // is still to come when the first stage starts.
    if (k == 0) begin : g_first
      assign rem_in = DW'(num_i >> 1);
      assign den_in = den_i;
      assign q_in   = '0;
      assign bit_in = num_i[0];
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign q_in   = q_q[k-1];
      assign bit_in = 1'b0;
    end

    assign cur  = {rem_in, bit_in};
    assign take = cur >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      q_q[k] <= {q_in[QW-2:0], take};
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k] <= take ? DW'(cur - {1'b0, den_in}) : cur[DW-1:0];
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = q_q[QW-1];

endmodule
